### rtl/core/ipks_pkg.sv
`default_nettype none
package ipks_pkg;

    localparam int MAX_DIM       = 1024;
    localparam int TOPK_MAX      = 16;
    localparam int ELEMENT_WIDTH = 16;
    localparam int ACC_WIDTH     = 40;
    localparam int PROD_WIDTH    = 2 * ELEMENT_WIDTH;
    localparam int POS_WIDTH     = $clog2(MAX_DIM + 2);
    localparam int ADDR_WIDTH    = $clog2(MAX_DIM);
    localparam int KEEP_WIDTH    = 5;
    localparam int CNT_WIDTH     = $clog2(TOPK_MAX + 1);
    localparam int IDX_WIDTH     = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;
    localparam int SRC_WIDTH     = 32;
    localparam int RANK_WIDTH    = 4;
    localparam int STATUS_WIDTH  = 3;
    localparam int KEEP_RESET    = 4;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_DOC    = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK          = 3'd0,
        ST_NO_DOCS     = 3'd1,
        ST_EMPTY_QUERY = 3'd2,
        ST_MISMATCH    = 3'd3,
        ST_NONE_KEPT   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OPEN_NONE  = 2'd0,
        OPEN_QUERY = 2'd1,
        OPEN_DOC   = 2'd2
    } open_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_INS,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic query_load;
        logic doc_start;
        logic mul;
        logic acc;
        logic ins;
        logic finish;
        logic emit_load;
    } dp_cmd_t;

    typedef struct packed {
        logic doc_last;
        logic out_free;
        logic emit_done;
    } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/ipks_ram.sv
`default_nettype none
module ipks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

### rtl/core/ipks_ctrl.sv
`default_nettype none
module ipks_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic [1:0]           s_command,
    output logic                      s_ready,
    output ipks_pkg::dp_cmd_t         cmd,
    input  wire ipks_pkg::dp_status_t stat
);

    ipks_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ipks_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ipks_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (ipks_pkg::command_t'(s_command))
                        ipks_pkg::CMD_QUERY: cmd.query_load = 1'b1;
                        ipks_pkg::CMD_DOC: begin
                            cmd.doc_start = 1'b1;
                            state_next    = ipks_pkg::S_MUL;
                        end
                        ipks_pkg::CMD_FINISH: begin
                            cmd.finish = 1'b1;
                            state_next = ipks_pkg::S_EMIT;
                        end
                        ipks_pkg::CMD_NONE: ;
                        default: ;
                    endcase
                end
            end
            ipks_pkg::S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ipks_pkg::S_ACC;
            end
            ipks_pkg::S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = stat.doc_last ? ipks_pkg::S_INS : ipks_pkg::S_IDLE;
            end
            ipks_pkg::S_INS: begin
                cmd.ins    = 1'b1;
                state_next = ipks_pkg::S_IDLE;
            end
            ipks_pkg::S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (stat.emit_done) begin
                        state_next = ipks_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = ipks_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/ipks_dp.sv
`default_nettype none
module ipks_dp (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire ipks_pkg::dp_cmd_t                         cmd,
    output ipks_pkg::dp_status_t                           stat,
    input  wire logic signed [ipks_pkg::ELEMENT_WIDTH-1:0] s_element_value,
    input  wire logic [ipks_pkg::SRC_WIDTH-1:0]            s_source_index,
    input  wire logic                                      s_last_of_vector,
    input  wire logic                                      cfg_we,
    input  wire logic [ipks_pkg::KEEP_WIDTH-1:0]           cfg_wdata,
    input  wire logic                                      m_ready,
    output logic                                           m_valid,
    output logic [ipks_pkg::SRC_WIDTH-1:0]                 m_result_source,
    output logic [ipks_pkg::RANK_WIDTH-1:0]                m_result_rank,
    output logic [ipks_pkg::STATUS_WIDTH-1:0]              m_status,
    output logic                                           m_last_result
);

    localparam int AW      = ipks_pkg::ACC_WIDTH;
    localparam int PW      = ipks_pkg::POS_WIDTH;
    localparam int EW      = ipks_pkg::ELEMENT_WIDTH;
    localparam int CW      = ipks_pkg::CNT_WIDTH;
    localparam int K       = ipks_pkg::TOPK_MAX;
    localparam int IDX_SEL = ipks_pkg::IDX_WIDTH;

    logic [ipks_pkg::KEEP_WIDTH-1:0] keep_reg, keep_next;
    logic [PW-1:0] qlen_reg, qlen_next, pos_reg, pos_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic doc_seen_reg, doc_seen_next, mism_reg, mism_next;
    ipks_pkg::open_t open_reg, open_next;
    logic [CW-1:0] kept_reg, kept_next, n_reg, n_next, idx_reg, idx_next;
    logic signed [AW-1:0] score_reg [K];
    logic signed [AW-1:0] score_next [K];
    logic [ipks_pkg::SRC_WIDTH-1:0] src_reg [K];
    logic [ipks_pkg::SRC_WIDTH-1:0] src_next [K];
    logic signed [EW-1:0] elem_reg, elem_next;
    logic [ipks_pkg::SRC_WIDTH-1:0] dsrc_reg, dsrc_next;
    logic last_reg, last_next, inrng_reg, inrng_next;
    logic signed [ipks_pkg::PROD_WIDTH-1:0] prod_reg, prod_next;
    ipks_pkg::status_t fstat_reg, fstat_next;
    logic mv_reg, mv_next;
    logic [ipks_pkg::SRC_WIDTH-1:0] msrc_reg, msrc_next;
    logic [ipks_pkg::RANK_WIDTH-1:0] mrank_reg, mrank_next;
    logic [ipks_pkg::STATUS_WIDTH-1:0] mstat_reg, mstat_next;
    logic mlast_reg, mlast_next;

    logic [PW-1:0] pos_eff, pos_adv;
    logic ram_we;
    logic signed [EW-1:0] ram_rdata;
    logic signed [AW:0] sum;
    logic [K-1:0] ge;
    logic [CW-1:0] n_calc;
    logic emit_last;

    ipks_ram #(
        .WIDTH(EW),
        .DEPTH(ipks_pkg::MAX_DIM)
    ) u_query_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (pos_eff[ipks_pkg::ADDR_WIDTH-1:0]),
        .wdata(s_element_value),
        .rdata(ram_rdata)
    );

    always_comb begin
        if (cmd.query_load) begin
            pos_eff = (open_reg != ipks_pkg::OPEN_QUERY) ? '0 : pos_reg;
        end else begin
            pos_eff = (open_reg != ipks_pkg::OPEN_DOC) ? '0 : pos_reg;
        end
        pos_adv = (pos_eff < PW'(ipks_pkg::MAX_DIM + 1)) ? pos_eff + PW'(1) : pos_eff;
        ram_we  = cmd.query_load && (pos_eff < PW'(ipks_pkg::MAX_DIM));
        sum     = {acc_reg[AW-1], acc_reg} + (AW+1)'(prod_reg);
        for (int i = 0; i < K; i++) begin
            ge[i] = (CW'(i) < kept_reg) && (score_reg[i] >= acc_reg);
        end
        n_calc = (keep_reg > ipks_pkg::KEEP_WIDTH'(K)) ? CW'(K) : CW'(keep_reg);
        if (n_calc > kept_reg) begin
            n_calc = kept_reg;
        end
        emit_last = (fstat_reg != ipks_pkg::ST_OK) || (idx_reg + CW'(1) == n_reg);
    end

    always_comb begin
        keep_next     = cfg_we ? cfg_wdata : keep_reg;
        qlen_next     = qlen_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        doc_seen_next = doc_seen_reg;
        mism_next     = mism_reg;
        open_next     = open_reg;
        kept_next     = kept_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        score_next    = score_reg;
        src_next      = src_reg;
        elem_next     = elem_reg;
        dsrc_next     = dsrc_reg;
        last_next     = last_reg;
        inrng_next    = inrng_reg;
        prod_next     = prod_reg;
        fstat_next    = fstat_reg;
        mv_next       = mv_reg;
        msrc_next     = msrc_reg;
        mrank_next    = mrank_reg;
        mstat_next    = mstat_reg;
        mlast_next    = mlast_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        if (cmd.query_load) begin
            if (open_reg == ipks_pkg::OPEN_DOC) begin
                mism_next = 1'b1;
            end
            if (open_reg != ipks_pkg::OPEN_QUERY) begin
                qlen_next = '0;
            end
            acc_next = '0;
            if (s_last_of_vector) begin
                qlen_next = (pos_adv > PW'(ipks_pkg::MAX_DIM)) ? PW'(ipks_pkg::MAX_DIM) : pos_adv;
                pos_next  = '0;
                open_next = ipks_pkg::OPEN_NONE;
            end else begin
                pos_next  = pos_adv;
                open_next = ipks_pkg::OPEN_QUERY;
            end
        end

        if (cmd.doc_start) begin
            if (open_reg != ipks_pkg::OPEN_DOC) begin
                acc_next = '0;
            end
            open_next     = ipks_pkg::OPEN_DOC;
            doc_seen_next = 1'b1;
            inrng_next    = (pos_eff < qlen_reg) && (pos_eff < PW'(ipks_pkg::MAX_DIM));
            pos_next      = pos_adv;
            elem_next     = s_element_value;
            dsrc_next     = s_source_index;
            last_next     = s_last_of_vector;
        end

        if (cmd.mul) begin
            prod_next = elem_reg * ram_rdata;
        end

        if (cmd.acc && inrng_reg) begin
            if (sum[AW] != sum[AW-1]) begin
                acc_next = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
            end else begin
                acc_next = sum[AW-1:0];
            end
        end

        if (cmd.ins) begin
            if ((pos_reg != qlen_reg) || (qlen_reg == '0)) begin
                mism_next = 1'b1;
            end else if (!ge[K-1]) begin
                if (kept_reg < CW'(K)) begin
                    kept_next = kept_reg + CW'(1);
                end
                for (int i = 0; i < K; i++) begin
                    if (!ge[i]) begin
                        if ((i == 0) || ge[(i == 0) ? 0 : i-1]) begin
                            score_next[i] = acc_reg;
                            src_next[i]   = dsrc_reg;
                        end else begin
                            score_next[i] = score_reg[(i == 0) ? 0 : i-1];
                            src_next[i]   = src_reg[(i == 0) ? 0 : i-1];
                        end
                    end
                end
            end
            pos_next  = '0;
            acc_next  = '0;
            open_next = ipks_pkg::OPEN_NONE;
        end

        if (cmd.finish) begin
            priority if (!doc_seen_reg) begin
                fstat_next = ipks_pkg::ST_NO_DOCS;
            end else if (qlen_reg == '0) begin
                fstat_next = ipks_pkg::ST_EMPTY_QUERY;
            end else if (mism_reg || (open_reg == ipks_pkg::OPEN_DOC)) begin
                fstat_next = ipks_pkg::ST_MISMATCH;
            end else if (n_calc == '0) begin
                fstat_next = ipks_pkg::ST_NONE_KEPT;
            end else begin
                fstat_next = ipks_pkg::ST_OK;
            end
            n_next        = n_calc;
            idx_next      = '0;
            acc_next      = '0;
            pos_next      = '0;
            doc_seen_next = 1'b0;
            mism_next     = 1'b0;
            kept_next     = '0;
            open_next     = ipks_pkg::OPEN_NONE;
        end

        if (cmd.emit_load) begin
            mv_next    = 1'b1;
            mstat_next = fstat_reg;
            mlast_next = emit_last;
            if (fstat_reg == ipks_pkg::ST_OK) begin
                msrc_next  = src_reg[idx_reg[IDX_SEL-1:0]];
                mrank_next = ipks_pkg::RANK_WIDTH'(idx_reg);
            end else begin
                msrc_next  = '0;
                mrank_next = '0;
            end
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg     <= ipks_pkg::KEEP_WIDTH'(ipks_pkg::KEEP_RESET);
            qlen_reg     <= '0;
            pos_reg      <= '0;
            acc_reg      <= '0;
            doc_seen_reg <= 1'b0;
            mism_reg     <= 1'b0;
            open_reg     <= ipks_pkg::OPEN_NONE;
            kept_reg     <= '0;
            mv_reg       <= 1'b0;
        end else begin
            keep_reg     <= keep_next;
            qlen_reg     <= qlen_next;
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            doc_seen_reg <= doc_seen_next;
            mism_reg     <= mism_next;
            open_reg     <= open_next;
            kept_reg     <= kept_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        score_reg <= score_next;
        src_reg   <= src_next;
        elem_reg  <= elem_next;
        dsrc_reg  <= dsrc_next;
        last_reg  <= last_next;
        inrng_reg <= inrng_next;
        prod_reg  <= prod_next;
        fstat_reg <= fstat_next;
        msrc_reg  <= msrc_next;
        mrank_reg <= mrank_next;
        mstat_reg <= mstat_next;
        mlast_reg <= mlast_next;
    end

    assign stat.doc_last  = last_reg;
    assign stat.out_free  = !mv_reg || m_ready;
    assign stat.emit_done = emit_last;

    assign m_valid         = mv_reg;
    assign m_result_source = msrc_reg;
    assign m_result_rank   = mrank_reg;
    assign m_status        = mstat_reg;
    assign m_last_result   = mlast_reg;

endmodule
`default_nettype wire

### rtl/core/inner_product_top_k_search_top.sv
// Top-k inner product search. Input items arrive on the s_ channel with a
// valid and ready handshake: command 0 loads one query element, command 1
// streams one document element, command 2 finishes and reports results.
// The keep count register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// A query element is written into the query memory. A document element passes
// through the query memory read, the registered multiplier and the saturating
// accumulator; the last element also inserts the score into the sorted list.
// A finish emits one result item per cycle, while the receiver takes them,
// through the m_ output register: between one and sixteen items, with last_result on the final one.
// The block takes no new item until the finish has loaded its final item.
// When the receiver stalls, the output register holds its item and the
// emission waits.
// Reset clears the query length, the list and all flags, sets the keep
// count to four and drops any pending result.
`default_nettype none
module inner_product_top_k_search_top (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_valid,
    output logic                                           s_ready,
    input  wire logic [1:0]                                s_command,
    input  wire logic signed [ipks_pkg::ELEMENT_WIDTH-1:0] s_element_value,
    input  wire logic [ipks_pkg::SRC_WIDTH-1:0]            s_source_index,
    input  wire logic                                      s_last_of_vector,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic [ipks_pkg::SRC_WIDTH-1:0]                 m_result_source,
    output logic [ipks_pkg::RANK_WIDTH-1:0]                m_result_rank,
    output logic [ipks_pkg::STATUS_WIDTH-1:0]              m_status,
    output logic                                           m_last_result,
    input  wire logic                                      cfg_we,
    input  wire logic [ipks_pkg::KEEP_WIDTH-1:0]           cfg_wdata
);

    ipks_pkg::dp_cmd_t    cmd;
    ipks_pkg::dp_status_t stat;

    ipks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_command(s_command),
        .s_ready  (s_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ipks_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_element_value (s_element_value),
        .s_source_index  (s_source_index),
        .s_last_of_vector(s_last_of_vector),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_result_source (m_result_source),
        .m_result_rank   (m_result_rank),
        .m_status        (m_status),
        .m_last_result   (m_last_result)
    );

endmodule
`default_nettype wire

### rtl/core/ipks_checker.sv
`default_nettype none
module ipks_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_result_source,
    input wire logic [3:0]  m_result_rank,
    input wire logic [2:0]  m_status,
    input wire logic        m_last_result
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_source))
        else $error("Stalled result changed.");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ipks_pkg::ST_OK) |-> m_last_result)
        else $error("Status item is not the final item.");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ipks_pkg::ST_OK) |->
        (m_result_rank == '0) && (m_result_source == '0))
        else $error("Status item carries a source or rank.");

endmodule

bind inner_product_top_k_search_top ipks_checker u_ipks_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_source(m_result_source),
    .m_result_rank  (m_result_rank),
    .m_status       (m_status),
    .m_last_result  (m_last_result)
);
`default_nettype wire

### tb/inner_product_top_k_search_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module inner_product_top_k_search_top_tb;
    import ipks_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [SRC_WIDTH-1:0]    source;
        logic [RANK_WIDTH-1:0]   rank;
        logic [STATUS_WIDTH-1:0] status;
        logic                    last;
    } ranked_item_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [1:0]                      s_command;
    logic signed [ELEMENT_WIDTH-1:0] s_element_value;
    logic [SRC_WIDTH-1:0]            s_source_index;
    logic                            s_last_of_vector;
    logic                            m_valid;
    logic                            m_ready;
    logic [SRC_WIDTH-1:0]            m_result_source;
    logic [RANK_WIDTH-1:0]           m_result_rank;
    logic [STATUS_WIDTH-1:0]         m_status;
    logic                            m_last_result;
    logic                            cfg_we;
    logic [KEEP_WIDTH-1:0]           cfg_wdata;

    inner_product_top_k_search_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_element_value (s_element_value),
        .s_source_index  (s_source_index),
        .s_last_of_vector(s_last_of_vector),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_source (m_result_source),
        .m_result_rank   (m_result_rank),
        .m_status        (m_status),
        .m_last_result   (m_last_result),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    // Predictor state.
    logic [KEEP_WIDTH-1:0]       keep_reg;
    logic signed [15:0]          query_mem [MAX_DIM];
    int                          query_len;
    logic signed [ACC_WIDTH-1:0] dot_sum;
    int                          elem_pos;
    bit                          docs_seen;
    bit                          dim_error;
    logic signed [ACC_WIDTH-1:0] top_scores [TOPK_MAX];
    logic [SRC_WIDTH-1:0]        top_sources [TOPK_MAX];
    int                          top_count;
    open_t                       open_vec;

    ranked_item_t expected_ranking[$];
    int           mismatch_count;
    int           idle_cycles;
    int           query_dim;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic predictor_reset();
        keep_reg = KEEP_WIDTH'(KEEP_RESET);
        query_len = 0;
        dot_sum = '0;
        elem_pos = 0;
        docs_seen = 0;
        dim_error = 0;
        top_count = 0;
        open_vec = OPEN_NONE;
    endtask

    task automatic push_result(input logic [31:0] src, input int rank, input status_t st,
                               input bit last);
        ranked_item_t it;
        it.source = src;
        it.rank = rank[RANK_WIDTH-1:0];
        it.status = st;
        it.last = last;
        expected_ranking = {expected_ranking, it};
    endtask

    task automatic rank_score(input logic signed [ACC_WIDTH-1:0] score,
                              input logic [31:0] src);
        int pos;
        pos = 0;
        while (pos < top_count && top_scores[pos] >= score) pos++;
        if (pos >= TOPK_MAX) return;
        if (top_count < TOPK_MAX) top_count++;
        for (int i = top_count - 1; i > pos; i--) begin
            top_scores[i] = top_scores[i-1];
            top_sources[i] = top_sources[i-1];
        end
        top_scores[pos] = score;
        top_sources[pos] = src;
    endtask

    task automatic predict_item(input logic [1:0] cmd, input logic signed [15:0] val,
                                input logic [31:0] src, input bit last);
        longint sum;
        int n;
        status_t st;
        case (cmd)
            CMD_QUERY: begin
                if (open_vec == OPEN_DOC) dim_error = 1;
                if (open_vec != OPEN_QUERY) begin
                    open_vec = OPEN_QUERY;
                    elem_pos = 0;
                    query_len = 0;
                end
                dot_sum = '0;
                if (elem_pos < MAX_DIM) query_mem[elem_pos] = val;
                if (elem_pos < MAX_DIM + 1) elem_pos++;
                if (last) begin
                    query_len = (elem_pos > MAX_DIM) ? MAX_DIM : elem_pos;
                    elem_pos = 0;
                    open_vec = OPEN_NONE;
                end
            end
            CMD_DOC: begin
                if (open_vec != OPEN_DOC) begin
                    open_vec = OPEN_DOC;
                    elem_pos = 0;
                    dot_sum = '0;
                end
                docs_seen = 1;
                if (elem_pos < query_len && elem_pos < MAX_DIM) begin
                    sum = longint'(dot_sum) + longint'(val) * longint'(query_mem[elem_pos]);
                    if (sum > 64'sd549755813887) sum = 64'sd549755813887;
                    if (sum < -64'sd549755813888) sum = -64'sd549755813888;
                    dot_sum = sum[ACC_WIDTH-1:0];
                end
                if (elem_pos < MAX_DIM + 1) elem_pos++;
                if (last) begin
                    if (elem_pos != query_len || query_len == 0) dim_error = 1;
                    else rank_score(dot_sum, src);
                    elem_pos = 0;
                    dot_sum = '0;
                    open_vec = OPEN_NONE;
                end
            end
            CMD_FINISH: begin
                if (open_vec == OPEN_DOC) dim_error = 1;
                n = (int'(keep_reg) > TOPK_MAX) ? TOPK_MAX : int'(keep_reg);
                if (n > top_count) n = top_count;
                st = ST_OK;
                if (!docs_seen) st = ST_NO_DOCS;
                else if (query_len == 0) st = ST_EMPTY_QUERY;
                else if (dim_error) st = ST_MISMATCH;
                else if (n == 0) st = ST_NONE_KEPT;
                if (st != ST_OK) push_result(32'h0, 0, st, 1'b1);
                else for (int r = 0; r < n; r++)
                    push_result(top_sources[r], r, ST_OK, r + 1 == n);
                dot_sum = '0;
                elem_pos = 0;
                docs_seen = 0;
                dim_error = 0;
                top_count = 0;
                open_vec = OPEN_NONE;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] val,
                             input logic [31:0] src, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_element_value <= val;
        s_source_index <= src;
        s_last_of_vector <= last;
        do @(posedge aclk); while (!s_ready);
        predict_item(cmd, val, src, last);
    endtask

    task automatic send_finish();
        send_item(CMD_FINISH, 16'sh0, 32'h0, 1'b0);
    endtask

    function automatic logic signed [15:0] rand_element();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        return 16'($urandom());
    endfunction

    task automatic send_query(input int len);
        for (int i = 0; i < len; i++) send_item(CMD_QUERY, rand_element(), $urandom(), i == len - 1);
    endtask

    task automatic send_doc(input int len, input logic [31:0] src);
        for (int i = 0; i < len; i++)
            send_item(CMD_DOC, rand_element(), (i == len - 1) ? src : $urandom(), i == len - 1);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_ranking.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_keep(input logic [KEEP_WIDTH-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        keep_reg = value;
    endtask

    task automatic test_status_cases();
        send_finish();
        send_doc(2, 32'h11);
        send_finish();
        send_query(3);
        send_doc(2, 32'h22);
        send_doc(3, 32'h33);
        send_finish();
        send_doc(2, 32'h44);
        send_finish();
        send_item(CMD_QUERY, 16'sh7fff, 32'h0, 1'b0);
        send_doc(3, 32'h55);
        send_item(CMD_NONE, 16'sh8000, 32'hffffffff, 1'b1);
        send_finish();
    endtask

    task automatic test_extremes_and_ties();
        send_item(CMD_QUERY, 16'sh8000, 32'h0, 1'b0);
        send_item(CMD_QUERY, 16'sh8000, 32'hffffffff, 1'b1);
        send_item(CMD_DOC, 16'sh8000, 32'h0, 1'b0);
        send_item(CMD_DOC, 16'sh8000, 32'hffffffff, 1'b1);
        send_item(CMD_DOC, 16'sh8000, 32'h0, 1'b0);
        send_item(CMD_DOC, 16'sh8000, 32'h0, 1'b1);
        send_item(CMD_DOC, 16'sh7fff, 32'h0, 1'b0);
        send_item(CMD_DOC, 16'sh7fff, 32'h5a5a5a5a, 1'b1);
        send_finish();
        write_keep(5'd0);
        send_doc(2, 32'h66);
        send_finish();
    endtask

    task automatic test_full_list();
        write_keep(5'd16);
        send_query(3);
        query_dim = 3;
        for (int d = 0; d < TOPK_MAX + 2; d++) send_doc(query_dim, $urandom());
        send_finish();
    endtask

    task automatic test_random_searches();
        int items;
        int r;
        int len;
        items = 0;
        query_dim = 4;
        send_query(query_dim);
        while (items < 290) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_doc(query_dim, $urandom());
                items += query_dim;
            end else if (r < 76) begin
                len = $urandom_range(1, 6);
                send_doc(len, $urandom());
                items += len;
            end else if (r < 86) begin
                send_finish();
                items++;
            end else if (r < 90) begin
                query_dim = $urandom_range(1, 6);
                send_query(query_dim);
                items += query_dim;
            end else if (r < 95) begin
                send_item(CMD_DOC, rand_element(), $urandom(), 1'b0);
                items++;
            end else begin
                send_item(CMD_NONE, rand_element(), $urandom(), 1'($urandom_range(0, 1)));
                items++;
            end
            if ($urandom_range(0, 29) == 0) begin
                send_finish();
                r = $urandom_range(0, 4);
                write_keep(KEEP_WIDTH'(r == 0 ? 31 : r == 1 ? 1 : $urandom_range(0, 31)));
                send_query(query_dim);
                items += 1 + query_dim;
            end
        end
        send_finish();
    endtask

    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = pick_gap();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        ranked_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ranking.size() == 0) begin
                report_mismatch("unexpected item, source", m_result_source, 32'h0);
            end else begin
                want = expected_ranking.pop_front();
                if (m_result_source !== want.source)
                    report_mismatch("result_source", m_result_source, want.source);
                if (m_result_rank !== want.rank)
                    report_mismatch("result_rank", 32'(m_result_rank), 32'(want.rank));
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_last_result !== want.last)
                    report_mismatch("last_result", 32'(m_last_result), 32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_NONE;
        s_element_value = '0;
        s_source_index = '0;
        s_last_of_vector = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        predictor_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_status_cases();
        test_extremes_and_ties();
        test_full_list();
        write_keep(5'd4);
        test_random_searches();
        wait_idle();
        if (mismatch_count == 0 && expected_ranking.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
